/* src/ste_pkg.sv */
// Shared types and constants for the sprite entry tile expander.
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

    localparam logic FMT_ORIGINAL = 1'b0;
    localparam logic FMT_BOOTLEG  = 1'b1;

    localparam int WORD_W  = 16;
    localparam int CODE_W  = 13;
    localparam int COLOR_W = 4;
    localparam int POS_W   = 10;
    localparam int IDX_W   = 3;
    localparam int TILE_SHIFT = 4;

    localparam logic [POS_W-1:0] BOOTLEG_Y_BASE = 10'd240;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                    disabled;
        logic [CODE_W-1:0]       code;
        logic [COLOR_W-1:0]      color;
        logic                    flip_x;
        logic                    flip_y;
        logic                    pri;
        logic [IDX_W-1:0]        width;
        logic [IDX_W-1:0]        height;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
    } t_entry;

    typedef struct packed {
        logic             emit;
        logic [IDX_W-1:0] col_idx;
        logic [IDX_W-1:0] row_idx;
        logic             last;
    } t_seq_ctl;

endpackage

`default_nettype wire

/* src/ste_decode.sv */
// Entry decoder: turns four sprite list words into one entry record.
`timescale 1ns / 1ps
`default_nettype none

module ste_decode
    import ste_pkg::*;
(
    input  wire logic              i_format,
    input  wire logic [WORD_W-1:0] i_word0,
    input  wire logic [WORD_W-1:0] i_word1,
    input  wire logic [WORD_W-1:0] i_word2,
    input  wire logic [WORD_W-1:0] i_word3,
    output t_entry                 o_entry
);

    logic [CODE_W-1:0] raw_code;

    assign raw_code = i_word1[CODE_W-1:0];

    always_comb begin
        o_entry.disabled = i_word0[15];
        // The 9-bit coordinates fold to signed values by sign extension.
        o_entry.sx = {i_word2[8], i_word2[8:0]};
        o_entry.sy = {i_word3[8], i_word3[8:0]};
        unique case (i_format)
            FMT_BOOTLEG: begin
                // Tile bits 11 and 12 trade places; always a single tile.
                o_entry.code   = {raw_code[11], raw_code[12], raw_code[10:0]};
                o_entry.color  = i_word2[15:12];
                o_entry.flip_x = i_word2[9];
                o_entry.flip_y = i_word2[10];
                o_entry.pri    = i_word2[7];
                o_entry.width  = '0;
                o_entry.height = '0;
                o_entry.sx     = {i_word3[8], i_word3[8:0]};
                o_entry.sy     = BOOTLEG_Y_BASE - {2'b00, i_word0[7:0]};
            end
            default: begin
                o_entry.code   = raw_code;
                o_entry.color  = i_word0[3:0];
                o_entry.flip_x = i_word0[13];
                o_entry.flip_y = i_word0[14];
                o_entry.pri    = i_word0[11];
                o_entry.width  = i_word0[9:7];
                o_entry.height = i_word0[6:4];
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/ste_seq.sv */
// Tile sequencer: walks the columns and rows of one entry.
`timescale 1ns / 1ps
`default_nettype none

module ste_seq
    import ste_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  t_entry    i_entry,
    input  wire logic i_slot_free,
    output logic      o_idle,
    output t_seq_ctl  o_ctl
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_width, r_height;
    logic             r_flip_x, r_flip_y;
    logic             col_end, row_end;

    assign col_end = (r_col == r_width);
    assign row_end = (r_row == r_height);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) begin
                n_state = ST_EMIT;
            end
            ST_EMIT: if (o_ctl.emit && o_ctl.last) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_idle        = 1'b0;
        o_ctl.emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_idle = 1'b1;
            ST_EMIT: o_ctl.emit = i_slot_free;
            default: o_idle = 1'b0;
        endcase
        o_ctl.last    = col_end && row_end;
        o_ctl.col_idx = r_flip_x ? r_width - r_col : r_col;
        o_ctl.row_idx = r_flip_y ? r_height - r_row : r_row;
    end

    // Rows run fastest, so tiles leave column by column.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_start) begin
            n_col = '0;
            n_row = '0;
        end else if (o_ctl.emit && !o_ctl.last) begin
            if (row_end) begin
                n_row = '0;
                n_col = r_col + 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_width  <= i_entry.width;
            r_height <= i_entry.height;
            r_flip_x <= i_entry.flip_x;
            r_flip_y <= i_entry.flip_y;
        end
    end

endmodule

`default_nettype wire

/* src/ste_tile_unit.sv */
// Tile unit: computes each tile's code and position and holds the output word.
`timescale 1ns / 1ps
`default_nettype none

module ste_tile_unit
    import ste_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  t_entry              i_entry,
    input  t_seq_ctl            i_ctl,
    input  wire logic           i_out_ready,
    output logic                o_slot_free,
    output logic                o_valid,
    output logic [CODE_W-1:0]   o_tile_code,
    output logic [COLOR_W-1:0]  o_color_bank,
    output logic                o_mirror_x,
    output logic                o_mirror_y,
    output logic [POS_W-1:0]    o_pos_x,
    output logic [POS_W-1:0]    o_pos_y,
    output logic                o_high_priority,
    output logic                o_last_tile
);

    t_entry            r_entry;
    logic [CODE_W-1:0] r_code;
    logic              r_valid, n_valid;
    logic [POS_W-1:0]  n_pos_x, n_pos_y;

    assign o_slot_free = !r_valid || i_out_ready;
    assign o_valid     = r_valid;

    // Offsets are 16 pixels per tile; results wrap to the 10-bit output.
    assign n_pos_x = r_entry.sx + POS_W'({i_ctl.col_idx, 4'b0000});
    assign n_pos_y = r_entry.sy + POS_W'({i_ctl.row_idx, 4'b0000});

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.emit) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_entry <= i_entry;
            r_code  <= i_entry.code;
        end else if (i_ctl.emit) begin
            r_code  <= r_code + 1'b1;
        end
        if (i_ctl.emit) begin
            o_tile_code     <= r_code;
            o_color_bank    <= r_entry.color;
            o_mirror_x      <= r_entry.flip_x;
            o_mirror_y      <= r_entry.flip_y;
            o_pos_x         <= n_pos_x;
            o_pos_y         <= n_pos_y;
            o_high_priority <= r_entry.pri;
            o_last_tile     <= i_ctl.last;
        end
    end

endmodule

`default_nettype wire

/* src/sprite_entry_tile_expander.sv */
// Top level of the sprite entry tile expander.
// Usage:
// The slave stream takes one sprite list entry per word: four 16-bit
// words packed into s_axis_tdata, word0 in the lowest bits. The master
// stream gives one 16x16 tile draw command per word, and m_axis_tlast
// marks the final tile of an entry.
// The one-bit format register is written through i_cfg_we and
// i_cfg_wdata: 0 selects the original big-sprite format, 1 the bootleg
// single-tile format. It should be written only while the block is idle.
// An enabled entry of W columns and H rows yields W*H tiles, column by
// column. Once the entry is accepted the sequencer enters its emit state
// and loads the output register with one tile per cycle while the
// receiver keeps m_axis_tready high; a disabled entry is accepted and
// gives nothing. The column and row counters of the sequencer set the
// order of the tiles.
// s_axis_tready is high only while the sequencer is idle. A stalled
// receiver freezes the output register and the sequencer with it. Reset
// empties the output register, idles the sequencer and selects the
// original format.
`timescale 1ns / 1ps
`default_nettype none

module sprite_entry_tile_expander
    import ste_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Format register write port.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    // Entry stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata fields from bit 0: word0[15:0], word1[31:16], word2[47:32], word3[63:48]
    input  wire logic [63:0] s_axis_tdata,
    // Tile command stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata fields from bit 0: tile_code[12:0], color_bank[16:13], mirror_x[17],
    // mirror_y[18], pos_x[28:19], pos_y[38:29], high_priority[39]
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    logic               r_entry_format;
    t_entry             entry;
    t_seq_ctl           ctl;
    logic               seq_idle;
    logic               slot_free;
    logic               start;
    logic [CODE_W-1:0]  tile_code;
    logic [COLOR_W-1:0] color_bank;
    logic               mirror_x, mirror_y, high_priority;
    logic [POS_W-1:0]   pos_x, pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_format <= FMT_ORIGINAL;
        end else if (i_cfg_we) begin
            r_entry_format <= i_cfg_wdata;
        end
    end

    ste_decode u_decode (
        .i_format (r_entry_format),
        .i_word0  (s_axis_tdata[15:0]),
        .i_word1  (s_axis_tdata[31:16]),
        .i_word2  (s_axis_tdata[47:32]),
        .i_word3  (s_axis_tdata[63:48]),
        .o_entry  (entry)
    );

    assign s_axis_tready = seq_idle;
    // A disabled entry is accepted and dropped without starting the sequencer.
    assign start = s_axis_tvalid && seq_idle && !entry.disabled;

    ste_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_entry     (entry),
        .i_slot_free (slot_free),
        .o_idle      (seq_idle),
        .o_ctl       (ctl)
    );

    ste_tile_unit u_tile (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_entry         (entry),
        .i_ctl           (ctl),
        .i_out_ready     (m_axis_tready),
        .o_slot_free     (slot_free),
        .o_valid         (m_axis_tvalid),
        .o_tile_code     (tile_code),
        .o_color_bank    (color_bank),
        .o_mirror_x      (mirror_x),
        .o_mirror_y      (mirror_y),
        .o_pos_x         (pos_x),
        .o_pos_y         (pos_y),
        .o_high_priority (high_priority),
        .o_last_tile     (m_axis_tlast)
    );

    assign m_axis_tdata = {high_priority, pos_y, pos_x, mirror_y, mirror_x,
                           color_bank, tile_code};

endmodule

`default_nettype wire

/* src/ste_checker.sv */
// Port-level checker for the sprite entry tile expander, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ste_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [63:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

    // Accepting an enabled entry closes the input at once.
    a_busy_after_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tdata[15] |=> !s_axis_tready)
        else $error("input reopened right after an enabled entry");

    // While a tile other than the final one of an entry is handed over, no new entry is taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("entry accepted while tiles of another are pending");

    // A stalled output word holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

endmodule

bind sprite_entry_tile_expander ste_checker u_ste_checker (.*);

`default_nettype wire
